[rtl/core/positional_list_insert_delete_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the positional list block
// Clocked on aclk. The first form is disabled while aresetn is low; the second
// also checks during reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PLC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define PLC_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PLC_ASSERT(name, prop, msg)
`define PLC_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

[rtl/core/plc_pkg.sv]
// ----------------------------------------------------------------------------
// plc_pkg
// Command and status codes, and the control types shared by the list modules.
// ----------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;
    localparam int DATA_W  = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    // Shift control broadcast to every cell
    typedef struct packed {
        logic  do_insert;
        logic  do_delete;
        data_t value;
    } cell_ctrl_t;

    // Per-request outcome from the controller
    typedef struct packed {
        logic [1:0] status;
        logic       rd_ok;
    } resp_t;

endpackage

`default_nettype wire

[rtl/core/plc_cell.sv]
// ----------------------------------------------------------------------------
// plc_cell
// One list entry. Takes the new value, its left neighbor on an insert shift,
// or its right neighbor on a delete shift; otherwise holds.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_cell
    import plc_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  wire logic          aclk,
    input  wire cell_ctrl_t    ctrl,
    input  wire logic [IW-1:0] index,
    input  wire data_t         left_data,
    input  wire data_t         right_data,
    output data_t              data,
    output data_t              rd_data
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    data_t data_reg;

    // Shift or load the entry
    always_ff @(posedge aclk) begin
        if (ctrl.do_insert) begin
            if (index == MY_IDX) begin
                data_reg <= ctrl.value;
            end else if (MY_IDX > index) begin
                data_reg <= left_data;
            end
        end else if (ctrl.do_delete) begin
            if (MY_IDX >= index) begin
                data_reg <= right_data;
            end
        end
    end

    assign data    = data_reg;
    // Drive the entry onto the read bus only when selected
    assign rd_data = (index == MY_IDX) ? data_reg : '0;

endmodule

`default_nettype wire

[rtl/core/plc_ctrl.sv]
// ----------------------------------------------------------------------------
// plc_ctrl
// Holds the entry count, checks each request against it and issues the
// shift control for the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none
`include "positional_list_insert_delete_top_defines.svh"

module plc_ctrl
    import plc_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CW    = 5,
    parameter int IW    = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [1:0]        cmd,
    input  wire logic [POS_W-1:0]  position,
    input  wire data_t             value,
    output cell_ctrl_t             ctrl,
    output logic [IW-1:0]          index,
    output resp_t                  resp,
    output logic [CW-1:0]          count_after
);

    localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [EW-1:0] pos_ext;
    logic [EW-1:0] cnt_ext;
    logic [EW-1:0] idx_ext;
    logic          pos_nz;
    logic          ins_in_range;
    logic          in_range;
    logic          is_full;
    logic          ins_ok;
    logic          del_ok;
    logic          rd_ok;
    logic [1:0]    status;

    // Range checks against the current count
    always_comb begin
        pos_ext      = EW'(position);
        cnt_ext      = EW'(cnt_reg);
        idx_ext      = pos_ext - EW'(1);
        pos_nz       = (position != '0);
        ins_in_range = pos_nz && (pos_ext <= cnt_ext + EW'(1));
        in_range     = pos_nz && (pos_ext <= cnt_ext);
        is_full      = (cnt_reg == FULL_COUNT);
    end

    // Decode the request
    always_comb begin
        ins_ok = 1'b0;
        del_ok = 1'b0;
        rd_ok  = 1'b0;
        status = STAT_RANGE;
        case (cmd)
            CMD_INSERT: begin
                if (ins_in_range) begin
                    if (is_full) begin
                        status = STAT_FULL;
                    end else begin
                        status = STAT_DONE;
                        ins_ok = 1'b1;
                    end
                end
            end
            CMD_DELETE: begin
                if (in_range) begin
                    status = STAT_DONE;
                    del_ok = 1'b1;
                end
            end
            CMD_READ: begin
                if (in_range) begin
                    status = STAT_DONE;
                    rd_ok  = 1'b1;
                end
            end
            default: begin
                status = STAT_RANGE;
            end
        endcase
    end

    // Advance the count
    always_comb begin
        cnt_next = cnt_reg;
        if (ins_ok) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (del_ok) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (accept) begin
            cnt_reg <= cnt_next;
        end
    end

    assign ctrl = '{do_insert: accept && ins_ok, do_delete: accept && del_ok, value: value};
    assign index       = idx_ext[IW-1:0];
    assign resp        = '{status: status, rd_ok: rd_ok};
    assign count_after = cnt_next;

    // Checks
    `PLC_ASSERT(a_count_bound, cnt_reg <= FULL_COUNT, "entry count above depth")
    `PLC_ASSERT(a_insert_grows,
                ctrl.do_insert |=> cnt_reg == $past(cnt_reg) + CW'(1),
                "insert did not grow count")
    `PLC_ASSERT(a_refused_holds,
                accept && status != STAT_DONE |=> $stable(cnt_reg),
                "refused request changed count")

endmodule

`default_nettype wire

[rtl/core/positional_list_insert_delete_top.sv]
// Positional list, chain of DEPTH cells with a count register.
// The result is registered in the cycle after the request is accepted.
// One request per cycle unless stalled; every cell shifts in the same cycle.
// s_ready stays high while the result register is empty or being drained.
// Reset (synchronous, aresetn low) empties the list and the result register;
// entry contents are not cleared and are never read past the count.
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top
// Bounded ordered list with insert, delete and read at a 1-based position.
// ----------------------------------------------------------------------------
`default_nettype none
`include "positional_list_insert_delete_top_defines.svh"

module positional_list_insert_delete_top
    import plc_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_cmd,
    input  wire logic [POS_W-1:0]   s_position,
    input  wire data_t              s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output data_t                   m_read_value,
    output logic [COUNT_W-1:0]      m_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                accept;
    cell_ctrl_t          ctrl;
    logic [IW-1:0]       index;
    resp_t               resp;
    logic [CW-1:0]       count_after;
    data_t               cell_data [DEPTH];
    data_t               cell_rd   [DEPTH];
    data_t               rd_bus;

    logic                m_valid_reg;
    logic [1:0]          status_reg;
    data_t               read_value_reg;
    logic [COUNT_W-1:0]  count_reg;

    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    plc_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW),
        .IW    (IW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .cmd         (s_cmd),
        .position    (s_position),
        .value       (s_value),
        .ctrl        (ctrl),
        .index       (index),
        .resp        (resp),
        .count_after (count_after)
    );

    // Chain of cells, each wired to its neighbors
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        data_t left_in;
        data_t right_in;
        if (i == 0) begin : g_first
            assign left_in = s_value;
        end else begin : g_mid_l
            assign left_in = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_mid_r
            assign right_in = cell_data[i+1];
        end
        plc_cell #(
            .IDX (i),
            .IW  (IW)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .index      (index),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // Merge the selected entry onto the read bus
    always_comb begin
        rd_bus = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_bus = rd_bus | cell_rd[k];
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg     <= resp.status;
            read_value_reg <= resp.rd_ok ? rd_bus : '0;
            count_reg      <= COUNT_W'(count_after);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_read_value = read_value_reg;
    assign m_count      = count_reg;

    // Checks
    `PLC_ASSERT_ALWAYS(a_idle_in_reset, !aresetn |-> !s_ready, "input ready during reset")
    `PLC_ASSERT(a_accept_gives_result, accept |=> m_valid, "accepted request left no result")
    `PLC_ASSERT(a_read_zero_on_refuse,
                m_valid && m_status != STAT_DONE |-> m_read_value == '0,
                "read value on refused request")

endmodule

`default_nettype wire

[verif/tb_positional_list_insert_delete_top.sv]
// ----------------------------------------------------------------------------
// tb_positional_list_insert_delete_top
// Self-checking bench for the positional list block. Requests are driven over
// the valid/ready input channel, a local list model predicts each response
// when its request is taken, and a checker compares every response field by
// field in order. Both sides idle at random and the response side holds off
// once for a long stretch so that the block fills and stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_positional_list_insert_delete_top;
    timeunit 1ns;
    timeprecision 1ps;

    import plc_pkg::*;

    localparam int         LIST_DEPTH  = 16;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES = 80;
    localparam int         CYCLE_LIMIT = 250000;
    localparam int         PRINT_CAP   = 40;

    typedef struct {
        logic [1:0]         status;
        data_t              read_value;
        logic [COUNT_W-1:0] count;
    } list_result_t;

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd        = CMD_INSERT;
    logic [POS_W-1:0]   s_position   = '0;
    data_t              s_value      = '0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic [1:0]         m_status;
    data_t              m_read_value;
    logic [COUNT_W-1:0] m_count;

    // Local list model
    data_t        list_cells [LIST_DEPTH];
    int           list_len = 0;
    list_result_t pending_results [$];

    // Length the stimulus expects, tracked as requests are offered
    int stim_len = 0;

    // Sides of the handshake
    bit   idle_on    = 1'b1;
    bit   sink_hold  = 1'b0;
    int   sink_gap   = 0;
    event hold_go;

    // Bookkeeping
    int mismatch_count = 0;
    int result_count   = 0;
    int cycle_count    = 0;
    int n_inserted     = 0;
    int n_deleted      = 0;
    int n_read_ok      = 0;
    int n_full         = 0;
    int n_range        = 0;
    int peak_len       = 0;
    int input_stalls   = 0;

    positional_list_insert_delete_top #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_position   (s_position),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_read_value (m_read_value),
        .m_count      (m_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Apply one command to the list model and return the response it gives
    function automatic list_result_t apply_list_command(logic [1:0] cmd,
                                                        logic [POS_W-1:0] pos,
                                                        data_t val);
        list_result_t r;
        int           p;
        int           j;
        r.status     = STAT_RANGE;
        r.read_value = '0;
        p            = int'(pos);
        case (cmd)
            CMD_INSERT: begin
                if (p >= 1 && p <= list_len + 1) begin
                    if (list_len >= LIST_DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        for (j = list_len; j >= p; j--)
                            list_cells[j] = list_cells[j-1];
                        list_cells[p-1] = val;
                        list_len++;
                        r.status = STAT_DONE;
                    end
                end
            end
            CMD_DELETE: begin
                if (p >= 1 && p <= list_len) begin
                    for (j = p - 1; j + 1 < list_len; j++)
                        list_cells[j] = list_cells[j+1];
                    list_len--;
                    r.status = STAT_DONE;
                end
            end
            CMD_READ: begin
                if (p >= 1 && p <= list_len) begin
                    r.read_value = list_cells[p-1];
                    r.status     = STAT_DONE;
                end
            end
            default: ;
        endcase
        r.count = list_len[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t ns: response %0d: %s is %0h, expected %0h",
                     $realtime, result_count, what, got, want);
    endtask

    // Predict each request as it is taken and tally what it exercises
    always @(posedge aclk) begin
        list_result_t exp_r;
        if (aresetn && s_valid && s_ready) begin
            exp_r = apply_list_command(s_cmd, s_position, s_value);
            pending_results.push_back(exp_r);
            if (exp_r.status == STAT_FULL)
                n_full++;
            else if (exp_r.status == STAT_RANGE)
                n_range++;
            else if (s_cmd == CMD_INSERT)
                n_inserted++;
            else if (s_cmd == CMD_DELETE)
                n_deleted++;
            else
                n_read_ok++;
            if (list_len > peak_len)
                peak_len = list_len;
        end
        if (aresetn && s_valid && !s_ready)
            input_stalls++;
    end

    // Compare each response with the oldest prediction
    always @(posedge aclk) begin
        list_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("response with nothing pending", {30'd0, m_status}, '0);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_status !== exp_r.status)
                    report_mismatch("status", {30'd0, m_status}, {30'd0, exp_r.status});
                if (m_read_value !== exp_r.read_value)
                    report_mismatch("read_value", m_read_value, exp_r.read_value);
                if (m_count !== exp_r.count)
                    report_mismatch("count", {27'd0, m_count}, {27'd0, exp_r.count});
            end
        end
    end

    // Response side: random stall bursts, or a long hold when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_hold) begin
            m_ready <= 1'b0;
        end else if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (sink_gap > 0) begin
            m_ready  <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_ready  <= 1'b0;
            sink_gap <= $urandom_range(0, 12);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Long hold on the response side, counted here
    always begin
        @(hold_go);
        @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d responses pending",
                 cycle_count, pending_results.size());
        $display("positional_list_insert_delete_top: mismatch");
        $finish;
    end

    // Offer one request and hold it until taken
    task automatic send_request(input logic [1:0] cmd, input int pos, input data_t val);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_position <= pos[POS_W-1:0];
        s_value    <= val;
        // keep the stimulus view of the length in step
        if (cmd == CMD_INSERT && pos >= 1 && pos <= stim_len + 1 && stim_len < LIST_DEPTH)
            stim_len++;
        else if (cmd == CMD_DELETE && pos >= 1 && pos <= stim_len)
            stim_len--;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic data_t random_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_entry();
        return (stim_len == 0) ? 1 : $urandom_range(1, stim_len);
    endfunction

    // One random request; weights pick the command, noise covers any code
    task automatic send_random_request(input int w_ins, input int w_del,
                                       input int w_rd, input int w_noise);
        int pick;
        pick = $urandom_range(0, w_ins + w_del + w_rd + w_noise - 1);
        if (pick < w_ins)
            send_request(CMD_INSERT, $urandom_range(1, stim_len + 1), random_word());
        else if (pick < w_ins + w_del)
            send_request(CMD_DELETE, pick_entry(), random_word());
        else if (pick < w_ins + w_del + w_rd)
            send_request(CMD_READ, pick_entry(), random_word());
        else
            send_request(2'($urandom_range(0, 3)), $urandom_range(0, 31), random_word());
    endtask

    // Edges of empty and small lists, each command, bad positions
    task automatic test_directed();
        send_request(CMD_READ,   1,  32'h1234_5678);
        send_request(CMD_DELETE, 1,  32'h0);
        send_request(CMD_INSERT, 0,  32'h1111_1111);
        send_request(CMD_INSERT, 2,  32'h2222_2222);
        send_request(CMD_INSERT, 1,  32'h7FFF_FFFF);
        send_request(CMD_INSERT, 2,  32'h8000_0000);
        send_request(CMD_INSERT, 1,  32'h0000_0000);
        send_request(CMD_INSERT, 2,  32'hFFFF_FFFF);
        send_request(CMD_UNUSED, 1,  32'hA5A5_A5A5);
        send_request(CMD_UNUSED, 31, 32'h5A5A_5A5A);
        for (int p = 1; p <= 4; p++)
            send_request(CMD_READ, p, 32'h0);
        send_request(CMD_READ,   5,  32'h0);
        send_request(CMD_READ,   0,  32'h0);
        send_request(CMD_DELETE, 5,  32'h0);
        send_request(CMD_DELETE, 2,  32'h0);
        send_request(CMD_READ,   2,  32'h0);
        send_request(CMD_DELETE, 3,  32'h0);
        send_request(CMD_DELETE, 1,  32'h0);
        send_request(CMD_READ,   31, 32'h0);
        send_request(CMD_INSERT, 31, 32'hDEAD_BEEF);
        send_request(CMD_DELETE, 1,  32'h0);
    endtask

    // Fill to capacity, try inserts at the boundary, read all, then drain
    task automatic test_fill_and_drain();
        while (stim_len < LIST_DEPTH)
            send_request(CMD_INSERT, $urandom_range(1, stim_len + 1), random_word());
        send_request(CMD_INSERT, 1,  random_word());
        send_request(CMD_INSERT, 17, random_word());
        send_request(CMD_INSERT, 18, random_word());
        send_request(CMD_INSERT, 0,  random_word());
        send_request(CMD_DELETE, 17, random_word());
        for (int p = 1; p <= LIST_DEPTH; p++)
            send_request(CMD_READ, p, random_word());
        while (stim_len > 0)
            send_request(CMD_DELETE, pick_entry(), random_word());
    endtask

    // Hold the response side while requests keep coming
    task automatic test_backpressure();
        -> hold_go;
        repeat (60) send_random_request(4, 2, 3, 1);
    endtask

    // Random phases that lean toward growth, shrinkage, reads or noise
    task automatic test_random_mix();
        for (int round = 0; round < 10; round++) begin
            if (round == 5)
                idle_on = 1'b0;
            if (round == 6)
                idle_on = 1'b1;
            case (round % 5)
                0: repeat (110) send_random_request(6, 2, 2, 1);
                1: repeat (110) send_random_request(3, 3, 3, 1);
                2: repeat (110) send_random_request(2, 6, 2, 1);
                3: repeat (110) send_random_request(3, 2, 6, 1);
                default: repeat (110) send_random_request(2, 2, 2, 4);
            endcase
        end
    endtask

    // Last stretch at full rate on both sides
    task automatic test_full_rate();
        idle_on = 1'b0;
        repeat (60) send_random_request(6, 2, 2, 1);
        repeat (100) send_random_request(3, 3, 3, 1);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_fill_and_drain();
        test_backpressure();
        test_fill_and_drain();
        test_random_mix();
        test_full_rate();

        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("responses never returned", pending_results.size(), '0);

        $display("covered %0d responses: %0d inserts, %0d deletes, %0d reads done",
                 result_count, n_inserted, n_deleted, n_read_ok);
        $display("refused %0d out of range and %0d full; peak length %0d, %0d input stalls",
                 n_range, n_full, peak_len, input_stalls);
        if (mismatch_count == 0) begin
            $display("positional_list_insert_delete_top: match");
        end else begin
            $display("positional_list_insert_delete_top: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
